[rtl/mshp_pkg.sv]
// Shared types and constants for the movie stream header parser.
// No dependencies; imported by every module of the block.
package mshp_pkg;

   localparam logic [2:0] KIND_HEADER     = 3'd0;
   localparam logic [2:0] KIND_NO_ENTRIES = 3'd1;
   localparam logic [2:0] KIND_ENTRY      = 3'd2;
   localparam logic [2:0] KIND_LAST_ENTRY = 3'd3;
   localparam logic [2:0] KIND_BAD_MAGIC  = 3'd4;
   localparam logic [2:0] KIND_TOO_SHORT  = 3'd5;

   localparam logic [1:0] CLASS_VIDEO = 2'd0;
   localparam logic [1:0] CLASS_AUDIO = 2'd1;
   localparam logic [1:0] CLASS_PCM   = 2'd2;
   localparam logic [1:0] CLASS_OTHER = 2'd3;

   localparam logic [7:0] SID_PRIVATE    = 8'hBD;
   localparam logic [3:0] SID_VIDEO_HI   = 4'hE;
   localparam logic [3:0] PID_AUDIO_HI   = 4'h0;
   localparam logic [3:0] PID_PCM_HI     = 4'h1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] version;
      logic [31:0] header_length;
      logic [31:0] payload_length;
      logic [47:0] start_stamp;
      logic [47:0] end_stamp;
      logic [15:0] entry_total;
      logic [7:0]  primary_id;
      logic [7:0]  secondary_id;
      logic [15:0] info_pair;
   } mshp_item_type;

   typedef struct packed {
      logic          valid;
      mshp_item_type item;
   } mshp_push_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h50;
         2'd1:    b = 8'h53;
         2'd2:    b = 8'h4D;
         default: b = 8'h46;
      endcase
      return b;
   endfunction

endpackage

[rtl/mshp_front.sv]
// Front end: accepts header bytes, tracks parse position and captures fields.
// Depends on mshp_pkg; pushes finished transactions into mshp_queue.
module mshp_front #(
   parameter int TABLE_START = 128,
   parameter int ENTRY_BYTES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  end_of_buffer,
   output mshp_pkg::mshp_push_type push
);
   import mshp_pkg::*;

   localparam int POS_W = $clog2(TABLE_START + 2);
   localparam int OFF_W = $clog2(ENTRY_BYTES);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_ENTRY  = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [15:0]      done_ff, done_in;
   logic [31:0]      ver_ff, ver_in;
   logic [31:0]      hlen_ff, hlen_in;
   logic [31:0]      plen_ff, plen_in;
   logic [47:0]      start_ff, start_in;
   logic [47:0]      end_ff, end_in;
   logic [15:0]      count_ff, count_in;
   logic [7:0]       sid_ff, sid_in;
   logic [7:0]       pid_ff, pid_in;
   logic [15:0]      info_ff, info_in;
   logic             push_v;
   logic [2:0]       kind;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      off_in   = off_ff;
      done_in  = done_ff;
      ver_in   = ver_ff;
      hlen_in  = hlen_ff;
      plen_in  = plen_ff;
      start_in = start_ff;
      end_in   = end_ff;
      count_in = count_ff;
      sid_in   = sid_ff;
      pid_in   = pid_ff;
      info_in  = info_ff;
      push_v   = 1'b0;
      kind     = KIND_HEADER;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff < POS_W'(4)) begin
                  if (data_byte != magic_byte(pos_ff[1:0])) begin
                     push_v   = 1'b1;
                     kind     = KIND_BAD_MAGIC;
                     phase_in = PH_DONE;
                  end
               end else if (pos_ff < POS_W'(8)) begin
                  ver_in[8*pos_ff[1:0] +: 8] = data_byte;
               end else if (pos_ff < POS_W'(12)) begin
                  hlen_in = {hlen_ff[23:0], data_byte};
               end else if (pos_ff < POS_W'(16)) begin
                  plen_in = {plen_ff[23:0], data_byte};
               end else if (pos_ff >= POS_W'('h54) && pos_ff < POS_W'('h5A)) begin
                  start_in = {start_ff[39:0], data_byte};
               end else if (pos_ff >= POS_W'('h5A) && pos_ff < POS_W'('h60)) begin
                  end_in = {end_ff[39:0], data_byte};
               end else if (pos_ff == POS_W'(TABLE_START)) begin
                  count_in = {data_byte, 8'h00};
               end else if (pos_ff == POS_W'(TABLE_START + 1)) begin
                  count_in = {count_ff[15:8], data_byte};
                  push_v   = 1'b1;
                  if (count_in == 16'd0) begin
                     kind     = KIND_NO_ENTRIES;
                     phase_in = PH_DONE;
                  end else begin
                     kind     = KIND_HEADER;
                     phase_in = PH_ENTRY;
                     off_in   = '0;
                     done_in  = '0;
                  end
               end
               if (phase_in == PH_HEADER && pos_ff < POS_W'(TABLE_START + 1)) begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
            PH_ENTRY: begin
               if (off_ff == OFF_W'(0)) begin
                  sid_in = data_byte;
               end else if (off_ff == OFF_W'(1)) begin
                  pid_in = data_byte;
               end else if (off_ff == OFF_W'(12)) begin
                  info_in = {8'h00, data_byte};
               end else if (off_ff == OFF_W'(13)) begin
                  info_in = {data_byte, info_ff[7:0]};
               end
               if (off_ff == OFF_W'(ENTRY_BYTES - 1)) begin
                  done_in = done_ff + 16'd1;
                  off_in  = '0;
                  push_v  = 1'b1;
                  if (done_in == count_ff) begin
                     kind     = KIND_LAST_ENTRY;
                     phase_in = PH_DONE;
                  end else begin
                     kind = KIND_ENTRY;
                  end
               end else begin
                  off_in = off_ff + OFF_W'(1);
               end
            end
            PH_DONE: begin
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
         if (end_of_buffer) begin
            if (phase_in != PH_DONE) begin
               push_v = 1'b1;
               kind   = KIND_TOO_SHORT;
            end
            phase_in = PH_HEADER;
            pos_in   = '0;
            off_in   = '0;
            done_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         off_ff   <= '0;
         done_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         off_ff   <= off_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ver_ff   <= ver_in;
      hlen_ff  <= hlen_in;
      plen_ff  <= plen_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      count_ff <= count_in;
      sid_ff   <= sid_in;
      pid_ff   <= pid_in;
      info_ff  <= info_in;
   end

   always_comb begin
      push.valid               = push_v;
      push.item.kind           = kind;
      push.item.version        = ver_in;
      push.item.header_length  = hlen_in;
      push.item.payload_length = plen_in;
      push.item.start_stamp    = start_in;
      push.item.end_stamp      = end_in;
      push.item.entry_total    = count_in;
      push.item.primary_id     = sid_in;
      push.item.secondary_id   = pid_in;
      push.item.info_pair      = info_in;
   end

endmodule

[rtl/mshp_queue.sv]
// Short transaction queue between the parser front end and the output stage.
// Depends on mshp_pkg for the queued item type and depth.
module mshp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  mshp_pkg::mshp_push_type push,
   input  logic                    pop,
   output logic                    full,
   output logic                    not_empty,
   output mshp_pkg::mshp_item_type head
);
   import mshp_pkg::*;

   mshp_item_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[rtl/mshp_back.sv]
// Output stage: classifies entries, masks unused fields, holds the result.
// Depends on mshp_pkg; pops transactions from mshp_queue.
module mshp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_not_empty,
   input  mshp_pkg::mshp_item_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_kind,
   output logic [31:0]             rsp_version,
   output logic [31:0]             rsp_header_length,
   output logic [31:0]             rsp_payload_length,
   output logic [47:0]             rsp_start_stamp,
   output logic [47:0]             rsp_end_stamp,
   output logic [15:0]             rsp_entry_total,
   output logic [7:0]              rsp_primary_id,
   output logic [7:0]              rsp_secondary_id,
   output logic [15:0]             rsp_info_pair,
   output logic [1:0]              rsp_stream_class,
   output logic [3:0]              rsp_channel_number
);
   import mshp_pkg::*;

   logic          valid_ff, valid_in;
   mshp_item_type res_ff, res_in;
   logic [1:0]    class_ff, class_in;
   logic [3:0]    chan_ff, chan_in;
   logic          has_hdr, has_ent;

   assign q_pop = q_not_empty && (!valid_ff || rsp_ready);

   always_comb begin
      has_hdr = (q_head.kind == KIND_HEADER) || (q_head.kind == KIND_NO_ENTRIES) ||
                (q_head.kind == KIND_ENTRY) || (q_head.kind == KIND_LAST_ENTRY);
      has_ent = (q_head.kind == KIND_ENTRY) || (q_head.kind == KIND_LAST_ENTRY);
      res_in      = '0;
      res_in.kind = q_head.kind;
      if (has_hdr) begin
         res_in.version        = q_head.version;
         res_in.header_length  = q_head.header_length;
         res_in.payload_length = q_head.payload_length;
         res_in.start_stamp    = q_head.start_stamp;
         res_in.end_stamp      = q_head.end_stamp;
         res_in.entry_total    = q_head.entry_total;
      end
      class_in = CLASS_VIDEO;
      chan_in  = '0;
      if (has_ent) begin
         res_in.primary_id   = q_head.primary_id;
         res_in.secondary_id = q_head.secondary_id;
         res_in.info_pair    = q_head.info_pair;
         if (q_head.primary_id[7:4] == SID_VIDEO_HI) begin
            class_in = CLASS_VIDEO;
         end else if (q_head.primary_id == SID_PRIVATE &&
                      q_head.secondary_id[7:4] == PID_AUDIO_HI) begin
            class_in = CLASS_AUDIO;
         end else if (q_head.primary_id == SID_PRIVATE &&
                      q_head.secondary_id[7:4] == PID_PCM_HI) begin
            class_in = CLASS_PCM;
         end else begin
            class_in = CLASS_OTHER;
         end
         chan_in = (q_head.primary_id == SID_PRIVATE) ? q_head.secondary_id[3:0]
                                                      : q_head.primary_id[3:0];
      end
      valid_in = q_pop ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         res_ff   <= res_in;
         class_ff <= class_in;
         chan_ff  <= chan_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = res_ff.kind;
   assign rsp_version        = res_ff.version;
   assign rsp_header_length  = res_ff.header_length;
   assign rsp_payload_length = res_ff.payload_length;
   assign rsp_start_stamp    = res_ff.start_stamp;
   assign rsp_end_stamp      = res_ff.end_stamp;
   assign rsp_entry_total    = res_ff.entry_total;
   assign rsp_primary_id     = res_ff.primary_id;
   assign rsp_secondary_id   = res_ff.secondary_id;
   assign rsp_info_pair      = res_ff.info_pair;
   assign rsp_stream_class   = class_ff;
   assign rsp_channel_number = chan_ff;

endmodule

[rtl/movie_stream_header_parser.sv]
// Movie stream header parser, top level: byte front end, queue, output stage.
// Depends on mshp_pkg, mshp_front, mshp_queue and mshp_back.
//
// Takes one header byte per clock and sustains one byte per cycle while
// req_ready is high. Each byte is parsed in the cycle it is accepted; a result
// it causes passes through a two-entry queue and the output register before
// it shows on rsp_. req_ready drops only when the queue is full, which happens
// only while the consumer holds rsp_ready low. Header fields are latched as
// they stream by; the stream table starts at TABLE_START and each entry is
// ENTRY_BYTES long. A byte flagged end_of_buffer closes the parse and the
// next byte starts a new header. No reset sweep; ready after reset.
module movie_stream_header_parser #(
   parameter int TABLE_START = 128,
   parameter int ENTRY_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_version,
   output logic [31:0] rsp_header_length,
   output logic [31:0] rsp_payload_length,
   output logic [47:0] rsp_start_stamp,
   output logic [47:0] rsp_end_stamp,
   output logic [15:0] rsp_entry_total,
   output logic [7:0]  rsp_primary_id,
   output logic [7:0]  rsp_secondary_id,
   output logic [15:0] rsp_info_pair,
   output logic [1:0]  rsp_stream_class,
   output logic [3:0]  rsp_channel_number
);
   import mshp_pkg::*;

   mshp_push_type push;
   mshp_item_type q_head;
   logic          q_full, q_not_empty, q_pop;

   assign req_ready = !q_full;

   mshp_front #(
      .TABLE_START(TABLE_START),
      .ENTRY_BYTES(ENTRY_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_valid && req_ready),
      .data_byte     (req_data_byte),
      .end_of_buffer (req_end_of_buffer),
      .push          (push)
   );

   mshp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   mshp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_version        (rsp_version),
      .rsp_header_length  (rsp_header_length),
      .rsp_payload_length (rsp_payload_length),
      .rsp_start_stamp    (rsp_start_stamp),
      .rsp_end_stamp      (rsp_end_stamp),
      .rsp_entry_total    (rsp_entry_total),
      .rsp_primary_id     (rsp_primary_id),
      .rsp_secondary_id   (rsp_secondary_id),
      .rsp_info_pair      (rsp_info_pair),
      .rsp_stream_class   (rsp_stream_class),
      .rsp_channel_number (rsp_channel_number)
   );

endmodule

[rtl/mshp_checker.sv]
// Port-level checks for movie_stream_header_parser, with its bind statement.
// Depends on mshp_pkg for the result kind codes.
module mshp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [31:0] rsp_version,
   input logic [15:0] rsp_entry_total,
   input logic [7:0]  rsp_primary_id,
   input logic [1:0]  rsp_stream_class,
   input logic [3:0]  rsp_channel_number
);
   import mshp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("result dropped or changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_BAD_MAGIC || rsp_kind == KIND_TOO_SHORT)
      |-> rsp_version == '0 && rsp_entry_total == '0 && rsp_primary_id == '0)
      else $error("error result carries field data");

   a_hdr_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_HEADER || rsp_kind == KIND_NO_ENTRIES)
      |-> rsp_primary_id == '0 && rsp_stream_class == '0 && rsp_channel_number == '0)
      else $error("header result carries entry data");

   a_count_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_HEADER || rsp_kind == KIND_ENTRY ||
                    rsp_kind == KIND_LAST_ENTRY) |-> rsp_entry_total != '0)
      else $error("entries reported with zero count");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= KIND_TOO_SHORT)
      else $error("undefined result kind");

endmodule

bind movie_stream_header_parser mshp_checker u_mshp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_kind           (rsp_kind),
   .rsp_version        (rsp_version),
   .rsp_entry_total    (rsp_entry_total),
   .rsp_primary_id     (rsp_primary_id),
   .rsp_stream_class   (rsp_stream_class),
   .rsp_channel_number (rsp_channel_number)
);

[tb/movie_stream_header_parser_tb.sv]
// Testbench for movie_stream_header_parser: directed and random header buffers,
// checked against an in-bench byte-level parse model, with random idling on both sides.
// Depends on mshp_pkg and rtl/movie_stream_header_parser.sv.
module movie_stream_header_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mshp_pkg::*;

   localparam int TABLE_START = 128;
   localparam int ENTRY_BYTES = 16;
   localparam int ITEM_TARGET = 1900;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_LIMIT = 20000;

   localparam logic [31:0] MAGIC_WORD = 32'h50534D46;
   localparam int VERSION_AT = 4;
   localparam int HLEN_AT    = 8;
   localparam int PLEN_AT    = 12;
   localparam int FIXED_END  = 16;
   localparam int START_AT   = 'h54;
   localparam int END_AT     = 'h5A;
   localparam int STAMPS_END = 'h60;
   localparam int ENT_SID     = 0;
   localparam int ENT_PID     = 1;
   localparam int ENT_INFO_LO = 12;
   localparam int ENT_INFO_HI = 13;

   typedef enum logic [1:0] {PH_HEADER, PH_ENTRIES, PH_DONE} phase_type;
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] version;
      logic [31:0] header_length;
      logic [31:0] payload_length;
      logic [47:0] start_stamp;
      logic [47:0] end_stamp;
      logic [15:0] entry_total;
      logic [7:0]  primary_id;
      logic [7:0]  secondary_id;
      logic [15:0] info_pair;
      logic [1:0]  stream_class;
      logic [3:0]  channel_number;
   } parse_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_version;
   logic [31:0] rsp_header_length;
   logic [31:0] rsp_payload_length;
   logic [47:0] rsp_start_stamp;
   logic [47:0] rsp_end_stamp;
   logic [15:0] rsp_entry_total;
   logic [7:0]  rsp_primary_id;
   logic [7:0]  rsp_secondary_id;
   logic [15:0] rsp_info_pair;
   logic [1:0]  rsp_stream_class;
   logic [3:0]  rsp_channel_number;

   movie_stream_header_parser #(
      .TABLE_START(TABLE_START),
      .ENTRY_BYTES(ENTRY_BYTES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_end_of_buffer(req_end_of_buffer),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_version(rsp_version),
      .rsp_header_length(rsp_header_length),
      .rsp_payload_length(rsp_payload_length),
      .rsp_start_stamp(rsp_start_stamp),
      .rsp_end_stamp(rsp_end_stamp),
      .rsp_entry_total(rsp_entry_total),
      .rsp_primary_id(rsp_primary_id),
      .rsp_secondary_id(rsp_secondary_id),
      .rsp_info_pair(rsp_info_pair),
      .rsp_stream_class(rsp_stream_class),
      .rsp_channel_number(rsp_channel_number)
   );

   // parse model state
   logic [20:0] hdr_pos;
   phase_type   phase;
   logic [31:0] acc_version;
   logic [31:0] acc_hlen;
   logic [31:0] acc_plen;
   logic [47:0] acc_start;
   logic [47:0] acc_end;
   logic [15:0] acc_total;
   logic [15:0] entries_seen;
   logic [5:0]  entry_byte;
   logic [15:0] entry_ids;
   logic [15:0] entry_info;

   parse_result_type pending_results[$];
   logic [7:0]       image[$];

   int  mismatches = 0;
   int  cycle_count = 0;
   int  bytes_sent = 0;
   int  parsed_bytes = 0;
   int  buffers_done = 0;
   int  results_predicted = 0;
   int  results_checked = 0;
   int  kind_seen[8];
   bit  steady_sender = 1'b0;

   initial forever #4 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [7:0] magic_at(input int idx);
      return MAGIC_WORD[31 - 8 * idx -: 8];
   endfunction

   function automatic logic [1:0] classify(input logic [7:0] sid, input logic [7:0] pid);
      if (sid[7:4] == SID_VIDEO_HI) return CLASS_VIDEO;
      if (sid == SID_PRIVATE && pid[7:4] == PID_AUDIO_HI) return CLASS_AUDIO;
      if (sid == SID_PRIVATE && pid[7:4] == PID_PCM_HI) return CLASS_PCM;
      return CLASS_OTHER;
   endfunction

   function automatic parse_result_type snapshot(input logic [2:0] kind, input bit with_hdr,
                                                 input bit with_entry);
      parse_result_type r;
      r = '0;
      r.kind = kind;
      if (with_hdr) begin
         r.version        = acc_version;
         r.header_length  = acc_hlen;
         r.payload_length = acc_plen;
         r.start_stamp    = acc_start;
         r.end_stamp      = acc_end;
         r.entry_total    = acc_total;
      end
      if (with_entry) begin
         r.primary_id     = entry_ids[15:8];
         r.secondary_id   = entry_ids[7:0];
         r.info_pair      = entry_info;
         r.stream_class   = classify(entry_ids[15:8], entry_ids[7:0]);
         r.channel_number = (entry_ids[15:8] == SID_PRIVATE) ? entry_ids[3:0] : entry_ids[11:8];
      end
      return r;
   endfunction

   task automatic clear_parse();
      hdr_pos      = '0;
      phase        = PH_HEADER;
      acc_version  = '0;
      acc_hlen     = '0;
      acc_plen     = '0;
      acc_start    = '0;
      acc_end      = '0;
      acc_total    = '0;
      entries_seen = '0;
      entry_byte   = '0;
      entry_ids    = '0;
      entry_info   = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic eob);
      parse_result_type r;
      logic emitted;
      int p;
      emitted = 1'b0;
      r = '0;
      p = hdr_pos;
      if (phase != PH_DONE || eob) parsed_bytes++;
      case (phase)
         PH_HEADER: begin
            if (p < VERSION_AT) begin
               if (b != magic_at(p)) begin
                  r = snapshot(KIND_BAD_MAGIC, 1'b0, 1'b0);
                  emitted = 1'b1;
                  phase = PH_DONE;
               end
            end else if (p < HLEN_AT) begin
               acc_version[8 * (p - VERSION_AT) +: 8] = b;
            end else if (p < PLEN_AT) begin
               acc_hlen = {acc_hlen[23:0], b};
            end else if (p < FIXED_END) begin
               acc_plen = {acc_plen[23:0], b};
            end else if (p >= START_AT && p < END_AT) begin
               acc_start = {acc_start[39:0], b};
            end else if (p >= END_AT && p < STAMPS_END) begin
               acc_end = {acc_end[39:0], b};
            end else if (p == TABLE_START) begin
               acc_total = {b, 8'h00};
            end else if (p == TABLE_START + 1) begin
               acc_total[7:0] = b;
               if (acc_total == 16'd0) begin
                  r = snapshot(KIND_NO_ENTRIES, 1'b1, 1'b0);
                  phase = PH_DONE;
               end else begin
                  r = snapshot(KIND_HEADER, 1'b1, 1'b0);
                  phase = PH_ENTRIES;
                  entry_byte = '0;
                  entries_seen = '0;
               end
               emitted = 1'b1;
            end
            if (phase == PH_HEADER && p < TABLE_START + 1) hdr_pos = hdr_pos + 1'b1;
         end
         PH_ENTRIES: begin
            if (entry_byte == ENT_SID) entry_ids = {b, 8'h00};
            else if (entry_byte == ENT_PID) entry_ids[7:0] = b;
            else if (entry_byte == ENT_INFO_LO) entry_info = {8'h00, b};
            else if (entry_byte == ENT_INFO_HI) entry_info[15:8] = b;
            if (entry_byte + 1 >= ENTRY_BYTES) begin
               entries_seen = entries_seen + 1'b1;
               entry_byte = '0;
               if (entries_seen == acc_total) begin
                  r = snapshot(KIND_LAST_ENTRY, 1'b1, 1'b1);
                  phase = PH_DONE;
               end else begin
                  r = snapshot(KIND_ENTRY, 1'b1, 1'b1);
               end
               emitted = 1'b1;
            end else begin
               entry_byte = entry_byte + 1'b1;
            end
         end
         default: ;
      endcase
      if (eob) begin
         if (phase != PH_DONE) begin
            r = snapshot(KIND_TOO_SHORT, 1'b0, 1'b0);
            emitted = 1'b1;
         end
         buffers_done++;
         clear_parse();
      end
      if (emitted) begin
         pending_results.insert(pending_results.size(), r);
         results_predicted++;
      end
   endtask

   function automatic int sender_gap();
      int roll;
      if (steady_sender) return 0;
      roll = $urandom_range(99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eob);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_buffer <= eob;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      parse_byte(b, eob);
   endtask

   // wait until every predicted result has been taken
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic build_image(input logic [15:0] total, input int entries, input int tail,
                              input fill_type fill);
      int i;
      int e;
      int k;
      int roll;
      logic [7:0] sid;
      logic [7:0] pid;
      image = {};
      for (i = 0; i < VERSION_AT; i++) image.insert(image.size(), magic_at(i));
      for (i = VERSION_AT; i < TABLE_START; i++) begin
         case (fill)
            FILL_ZERO: image.insert(image.size(), 8'h00);
            FILL_ONES: image.insert(image.size(), 8'hFF);
            default:   image.insert(image.size(), 8'($urandom_range(255)));
         endcase
      end
      image.insert(image.size(), total[15:8]);
      image.insert(image.size(), total[7:0]);
      for (e = 0; e < entries; e++) begin
         roll = $urandom_range(9);
         sid = 8'($urandom_range(255));
         pid = 8'($urandom_range(255));
         if (roll < 2) begin
            sid[7:4] = SID_VIDEO_HI;
         end else if (roll < 5) begin
            sid = SID_PRIVATE;
            pid[7:4] = roll[0] ? PID_AUDIO_HI : PID_PCM_HI;
         end else if (roll < 7) begin
            sid = SID_PRIVATE;
         end
         for (k = 0; k < ENTRY_BYTES; k++) begin
            if (k == ENT_SID) image.insert(image.size(), sid);
            else if (k == ENT_PID) image.insert(image.size(), pid);
            else image.insert(image.size(), 8'($urandom_range(255)));
         end
      end
      for (i = 0; i < tail; i++) image.insert(image.size(), 8'($urandom_range(255)));
   endtask

   task automatic send_image(input int cut);
      int i;
      for (i = 0; i < cut; i++) send_byte(image[i], i == cut - 1);
   endtask

   // magic mismatches at positions 0, 2 and 3, early ends inside the magic
   task automatic test_magic_edges();
      send_byte(magic_at(0), 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(magic_at(0), 1'b0);
      send_byte(magic_at(1), 1'b1);
      send_byte(magic_at(0), 1'b0);
      send_byte(magic_at(1), 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(magic_at(0), 1'b0);
      send_byte(magic_at(1), 1'b0);
      send_byte(magic_at(2), 1'b0);
      send_byte(magic_at(3) ^ 8'h01, 1'b0);
      send_byte(magic_at(3), 1'b1);
      send_byte(magic_at(0), 1'b0);
      send_byte(magic_at(1), 1'b0);
      send_byte(magic_at(2), 1'b0);
      send_byte(magic_at(3), 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(magic_at(0) ^ 8'h80, 1'b1);
   endtask

   // whole headers: empty table, exact ends, truncation on result bytes, max count
   task automatic test_header_extremes();
      build_image(16'd0, 0, 0, FILL_ONES);
      send_image(image.size());
      build_image(16'd0, 0, 5, FILL_ZERO);
      send_image(image.size());
      build_image(16'd1, 1, 3, FILL_ZERO);
      send_image(image.size());
      build_image(16'hFFFF, 3, 0, FILL_RANDOM);
      send_image(TABLE_START + 2 + 2 * ENTRY_BYTES + 7);
      build_image(16'd2, 2, 0, FILL_ONES);
      send_image(TABLE_START + 2);
      build_image(16'd1, 1, 0, FILL_RANDOM);
      send_image(image.size());
      build_image(16'd3, 3, 2, FILL_RANDOM);
      send_image(TABLE_START + 2 + ENTRY_BYTES);
   endtask

   task automatic test_random_buffers();
      int roll;
      int len;
      int keep;
      int i;
      int k;
      int entries;
      logic [15:0] total;
      fill_type fill;
      while (bytes_sent < ITEM_TARGET) begin
         steady_sender = ($urandom_range(3) == 0);
         roll = $urandom_range(99);
         if (roll < 20) begin
            len = $urandom_range(8, 1);
            keep = $urandom_range(4);
            for (i = 0; i < len; i++)
               send_byte(i < keep ? magic_at(i) : 8'($urandom_range(255)), i == len - 1);
         end else begin
            if (roll < 80) begin
               total = 16'($urandom_range(3));
               entries = total;
            end else begin
               total = 16'($urandom_range(16'hFFFF));
               entries = $urandom_range(2);
            end
            k = $urandom_range(9);
            fill = (k == 0) ? FILL_ZERO : (k == 1) ? FILL_ONES : FILL_RANDOM;
            build_image(total, entries, $urandom_range(4), fill);
            if ($urandom_range(9) == 0) begin
               k = $urandom_range(3);
               image[k] = image[k] ^ (8'h01 << $urandom_range(7));
            end
            if ($urandom_range(99) < 55) send_image(image.size());
            else send_image($urandom_range(image.size(), 1));
         end
      end
      steady_sender = 1'b0;
   endtask

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   initial begin : result_checker
      parse_result_type want;
      int ready_left;
      bit ready_level;
      int roll;
      ready_left = 0;
      ready_level = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            kind_seen[rsp_kind]++;
            if (pending_results.size() == 0) begin
               $error("rsp: transaction with no result expected, kind %0d", rsp_kind);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               check_field("kind", want.kind, rsp_kind);
               check_field("version", want.version, rsp_version);
               check_field("header_length", want.header_length, rsp_header_length);
               check_field("payload_length", want.payload_length, rsp_payload_length);
               check_field("start_stamp", want.start_stamp, rsp_start_stamp);
               check_field("end_stamp", want.end_stamp, rsp_end_stamp);
               check_field("entry_total", want.entry_total, rsp_entry_total);
               check_field("primary_id", want.primary_id, rsp_primary_id);
               check_field("secondary_id", want.secondary_id, rsp_secondary_id);
               check_field("info_pair", want.info_pair, rsp_info_pair);
               check_field("stream_class", want.stream_class, rsp_stream_class);
               check_field("channel_number", want.channel_number, rsp_channel_number);
            end
         end
         if (ready_left == 0) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
               ready_level = 1'b1;
               ready_left = $urandom_range(40, 1);
            end else if (roll < 92) begin
               ready_level = 1'b0;
               ready_left = $urandom_range(3, 1);
            end else begin
               ready_level = 1'b0;
               ready_left = $urandom_range(40, 10);
            end
         end
         rsp_ready <= ready_level;
         ready_left--;
      end
   end

   initial begin : stimulus
      int waited;
      clear_parse();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_magic_edges();
      settle();
      test_header_extremes();
      settle();
      test_random_buffers();
      req_valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         mismatches++;
      end
      $display("Covered %0d buffers, %0d bytes sent (%0d parsed), %0d results checked",
               buffers_done, bytes_sent, parsed_bytes, results_checked);
      $display("By kind: header %0d, empty %0d, entry %0d, last %0d, bad magic %0d, short %0d",
               kind_seen[KIND_HEADER], kind_seen[KIND_NO_ENTRIES], kind_seen[KIND_ENTRY],
               kind_seen[KIND_LAST_ENTRY], kind_seen[KIND_BAD_MAGIC], kind_seen[KIND_TOO_SHORT]);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
